// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pph_pkg.sv =====
// Shared constants and types of the PPG peak and heart rate block.
package pph_pkg;

    localparam int SLOTS  = 8;
    localparam int PTR_W  = $clog2(SLOTS);
    localparam int FILL_W = $clog2(SLOTS + 1);
    localparam int S_W    = 16 + FILL_W;
    localparam int NUM_W  = 24 + FILL_W;
    localparam int QD     = 2;

    typedef enum logic [2:0] {
        REG_MIN_AMP   = 3'd0,
        REG_MIN_IV    = 3'd1,
        REG_MAX_IV    = 3'd2,
        REG_WARMUP    = 3'd3,
        REG_DECAY     = 3'd4,
        REG_MIN_N     = 3'd5,
        REG_ALPHA     = 3'd6
    } t_reg;

    typedef struct packed {
        logic [15:0] min_amp;
        logic [15:0] min_iv;
        logic [15:0] max_iv;
        logic [15:0] warmup;
        logic [9:0]  decay;
        logic [3:0]  min_n;
        logic [15:0] alpha;
    } t_cfg;

    // One classified item handed from the front to the rate engine.
    typedef struct packed {
        logic                    peak;
        logic [FILL_W-1:0]       fill;
        logic [31:0]             beats;
        logic [SLOTS-1:0][15:0]  ring;
    } t_job;

endpackage

// ===== hw/rtl/pph_front.sv =====
// Front end: peak detection, baseline tracking and interval ring update.
module pph_front import pph_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_push,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [15:0] i_ir_sample,
    input  logic [31:0] i_time_ms,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_job        o_q_job
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_UPD} t_state;

    t_state r_state;
    logic r_kind, r_ge, r_armed;
    logic [15:0] r_x, r_rh, r_rl, r_warm, r_ls, r_os;
    logic [31:0] r_now, r_base, r_lbt, r_beats;
    logic [47:0] r_prod;
    logic [9:0] r_spc;
    logic [SLOTS-1:0][15:0] r_ring;
    logic [PTR_W-1:0] r_ptr;
    logic [FILL_W-1:0] r_fill;

    logic n_armed, n_peak;
    logic [15:0] n_rh, n_rl, n_warm;
    logic [31:0] n_base, n_lbt, n_beats;
    logic [9:0] n_spc;
    logic [SLOTS-1:0][15:0] n_ring;
    logic [PTR_W-1:0] n_ptr;
    logic [FILL_W-1:0] n_fill;

    logic [31:0] target, diff, iv;
    logic [48:0] dn_sum;
    logic [15:0] rh1, rl1, dec, thr;
    logic [10:0] nxt;
    logic [16:0] rng;
    logic dec_on, big, active, cand, iv_ok;

    assign target  = {r_x, 16'd0};
    assign diff    = (target >= r_base) ? target - r_base : r_base - target;
    assign o_ready = (r_state == S_IDLE) && !i_q_full;
    assign o_q_push = (r_state == S_UPD);
    assign o_q_job  = '{peak: n_peak, fill: n_fill, beats: n_beats, ring: n_ring};

    always_comb begin
        rh1    = (r_x > r_rh) ? r_x : r_rh;
        rl1    = (r_x < r_rl) ? r_x : r_rl;
        nxt    = {1'b0, r_spc} + 11'd1;
        dec_on = nxt > {1'b0, i_cfg.decay};
        dec    = (rh1 >= rl1) ? ((rh1 - rl1) >> 5) : 16'd0;
        n_rh   = dec_on ? rh1 - dec : rh1;
        n_rl   = dec_on ? rl1 + dec : rl1;
        n_spc  = dec_on ? 10'd0 : nxt[9:0];
        rng    = {1'b0, n_rh} - {1'b0, n_rl};
        big    = $signed(rng) > $signed({1'b0, i_cfg.min_amp});
        dn_sum = {1'b0, r_prod} + 49'd65535;
        if (r_base == 32'd0) begin
            n_base = target;
        end else if (r_ge) begin
            n_base = r_base + r_prod[47:16];
        end else begin
            n_base = r_base - dn_sum[47:16];
        end
        thr    = n_base[31:16];
        n_warm = (r_warm != 16'hFFFF) ? r_warm + 16'd1 : r_warm;
        active = n_warm >= i_cfg.warmup;
        cand   = r_armed && (r_ls > r_os) && (r_ls > r_x) && (r_ls > thr) && big;
        iv     = r_now - r_lbt;
        iv_ok  = (iv >= {16'd0, i_cfg.min_iv}) && (iv <= {16'd0, i_cfg.max_iv});
        n_armed = r_armed;
        n_lbt   = r_lbt;
        n_ring  = r_ring;
        n_ptr   = r_ptr;
        n_fill  = r_fill;
        n_beats = r_beats;
        n_peak  = 1'b0;
        if (active) begin
            if (cand) begin
                if (iv_ok) begin
                    n_ring[r_ptr] = iv[15:0];
                    n_ptr  = (r_ptr == PTR_W'(SLOTS - 1)) ? '0 : r_ptr + PTR_W'(1);
                    n_fill = (r_fill < FILL_W'(SLOTS)) ? r_fill + FILL_W'(1) : r_fill;
                    n_beats = r_beats + 32'd1;
                    n_peak = 1'b1;
                    n_spc  = 10'd0;
                end
                n_lbt   = r_now;
                n_armed = 1'b0;
            end else if (!r_armed && (r_x < thr)) begin
                n_armed = 1'b1;
            end
        end
        // A restart clears detection state but keeps the sample history.
        if (r_kind) begin
            n_rh = 16'd0;
            n_rl = 16'hFFFF;
            n_spc = 10'd0;
            n_armed = 1'b1;
            n_base = 32'd0;
            n_warm = 16'd0;
            n_lbt = r_now;
            n_ring = '0;
            n_ptr = '0;
            n_fill = '0;
            n_beats = 32'd0;
            n_peak = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rh <= 16'd0;
            r_rl <= 16'hFFFF;
            r_spc <= 10'd0;
            r_armed <= 1'b1;
            r_base <= 32'd0;
            r_warm <= 16'd0;
            r_ls <= 16'd0;
            r_os <= 16'd0;
            r_lbt <= 32'd0;
            r_ring <= '0;
            r_ptr <= '0;
            r_fill <= '0;
            r_beats <= 32'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_push && o_ready) begin
                        r_kind <= i_kind;
                        r_x <= i_ir_sample;
                        r_now <= i_time_ms;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_ge <= target >= r_base;
                    r_prod <= diff * {32'd0, i_cfg.alpha};
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_rh <= n_rh;
                    r_rl <= n_rl;
                    r_spc <= n_spc;
                    r_armed <= n_armed;
                    r_base <= n_base;
                    r_warm <= n_warm;
                    r_lbt <= n_lbt;
                    r_ring <= n_ring;
                    r_ptr <= n_ptr;
                    r_fill <= n_fill;
                    r_beats <= n_beats;
                    if (!r_kind) begin
                        r_os <= r_ls;
                        r_ls <= r_x;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/pph_fifo.sv =====
// Short job queue between the detection front end and the rate engine.
module pph_fifo import pph_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty
);

    localparam int A_W = (QD > 1) ? $clog2(QD) : 1;
    localparam int C_W = $clog2(QD + 1);

    t_job r_mem [QD];
    logic [A_W-1:0] r_wr, r_rd;
    logic [C_W-1:0] r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == C_W'(QD));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == A_W'(QD - 1)) ? '0 : r_wr + A_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == A_W'(QD - 1)) ? '0 : r_rd + A_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + C_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - C_W'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/pph_back.sv =====
// Rate engine: two passes over the interval ring, a serial divider, output register.
module pph_back import pph_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_empty,
    input  t_job        i_q_job,
    output logic        o_q_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output logic        o_peak_found,
    output logic [15:0] o_heart_rate_q8,
    output logic [3:0]  o_stored_intervals,
    output logic [31:0] o_beat_total
);

    localparam int A_W   = FILL_W + 20;
    localparam int L_W   = FILL_W + 24;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [23:0] RATE_K = 24'd15360000;

    typedef enum logic [3:0] {
        B_IDLE, B_START, B_P1, B_MID, B_P2, B_SEL, B_CHK, B_DIV, B_SAT, B_DONE
    } t_state;

    t_state r_state;
    t_job r_job;
    logic [FILL_W-1:0] r_i, r_n1, r_n2, r_n;
    logic [S_W-1:0] r_s1, r_s2, r_s, r_rem;
    logic r_lim, r_ovalid;
    logic [NUM_W-1:0] r_num, r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0] r_rate;

    logic [15:0] v;
    logic in_win, near;
    logic [A_W-1:0] a, b, d, s3;
    logic [L_W-1:0] n60k, s30, s200;
    logic [S_W:0] trial;
    logic last;

    assign o_q_pop = (r_state == B_IDLE) && !i_q_empty;
    assign o_empty = !r_ovalid;
    assign last = (r_i == r_job.fill);

    always_comb begin
        v      = r_job.ring[r_i[PTR_W-1:0]];
        in_win = (v >= i_cfg.min_iv) && (v <= i_cfg.max_iv);
        a      = A_W'(A_W'(r_n1) * A_W'(v)) * A_W'(10);
        b      = A_W'(r_s1) * A_W'(10);
        d      = (a > b) ? a - b : b - a;
        s3     = A_W'(r_s1) * A_W'(3);
        near   = d <= s3;
        n60k   = L_W'(r_n) * L_W'(60000);
        s30    = L_W'(r_s) * L_W'(30);
        s200   = L_W'(r_s) * L_W'(200);
        trial  = {r_rem, r_num[NUM_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // In B_DONE the output register is reloaded in the same cycle it is popped.
            if (i_pop && r_ovalid && (r_state != B_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_job <= i_q_job;
                        r_state <= B_START;
                    end
                end
                B_START: begin
                    r_rate <= 16'd0;
                    r_i <= '0;
                    r_s1 <= '0;
                    r_n1 <= '0;
                    if (32'(r_job.fill) < 32'(i_cfg.min_n)) begin
                        r_state <= B_DONE;
                    end else begin
                        r_state <= B_P1;
                    end
                end
                B_P1: begin
                    if (last) begin
                        r_state <= B_MID;
                    end else begin
                        if (in_win) begin
                            r_s1 <= r_s1 + S_W'(v);
                            r_n1 <= r_n1 + FILL_W'(1);
                        end
                        r_i <= r_i + FILL_W'(1);
                    end
                end
                B_MID: begin
                    r_i <= '0;
                    r_s2 <= '0;
                    r_n2 <= '0;
                    r_state <= (r_n1 < FILL_W'(2)) ? B_DONE : B_P2;
                end
                B_P2: begin
                    if (last) begin
                        r_state <= B_SEL;
                    end else begin
                        if (near) begin
                            r_s2 <= r_s2 + S_W'(v);
                            r_n2 <= r_n2 + FILL_W'(1);
                        end
                        r_i <= r_i + FILL_W'(1);
                    end
                end
                B_SEL: begin
                    // Too few survivors of outlier rejection: fall back to the mean.
                    if (r_n2 < FILL_W'(2)) begin
                        r_n <= r_n1;
                        r_s <= r_s1;
                        r_lim <= 1'b0;
                    end else begin
                        r_n <= r_n2;
                        r_s <= r_s2;
                        r_lim <= 1'b1;
                    end
                    r_state <= B_CHK;
                end
                B_CHK: begin
                    if ((r_s == '0) || (r_lim && ((n60k < s30) || (n60k > s200)))) begin
                        r_state <= B_DONE;
                    end else begin
                        r_num <= NUM_W'(RATE_K) * NUM_W'(r_n);
                        r_rem <= '0;
                        r_quo <= '0;
                        r_cnt <= CNT_W'(NUM_W);
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    if (trial >= {1'b0, r_s}) begin
                        r_rem <= S_W'(trial - {1'b0, r_s});
                        r_quo <= {r_quo[NUM_W-2:0], 1'b1};
                    end else begin
                        r_rem <= trial[S_W-1:0];
                        r_quo <= {r_quo[NUM_W-2:0], 1'b0};
                    end
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= B_SAT;
                    end
                end
                B_SAT: begin
                    r_rate <= (r_quo > NUM_W'(16'hFFFF)) ? 16'hFFFF : r_quo[15:0];
                    r_state <= B_DONE;
                end
                B_DONE: begin
                    if (!r_ovalid || i_pop) begin
                        r_ovalid <= 1'b1;
                        o_peak_found <= r_job.peak;
                        o_heart_rate_q8 <= r_rate;
                        o_stored_intervals <= r_job.fill[3:0];
                        o_beat_total <= r_job.beats;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/pulse_peak_heart_rate_top.sv =====
// Top level of the PPG peak detector and heart rate estimator.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+------------------------------------------
//  item in   | input     | i_push / o_full    | i_kind, i_ir_sample, i_time_ms
//  result    | output    | o_empty / i_pop    | o_peak_found, o_heart_rate_q8,
//            |           |                    | o_stored_intervals, o_beat_total
//  config    | input     | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// The front end handles each item by capture, the baseline multiply, and
// the state update that pushes a job into a two-entry queue, and takes no new
// item until that update is done. In the rate engine the bit-serial divider,
// when a job reaches it, outlasts both passes over a full ring of eight intervals.
// Reset is synchronous and active low; it restores the register defaults and
// the detection state and empties the queue and the output register.
// A result that is not popped stalls the rate engine, which in turn lets the
// queue fill and raises o_full.
module pulse_peak_heart_rate_top import pph_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_kind,
    input  logic [15:0] i_ir_sample,
    input  logic [31:0] i_time_ms,
    input  logic        i_pop,
    output logic        o_empty,
    output logic        o_peak_found,
    output logic [15:0] o_heart_rate_q8,
    output logic [3:0]  o_stored_intervals,
    output logic [31:0] o_beat_total,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cfg r_cfg;
    logic front_ready, q_full, q_push, q_empty, q_pop;
    t_job q_in, q_out;

    // Configuration registers; writes to an unused index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_amp <= 16'd100;
            r_cfg.min_iv  <= 16'd300;
            r_cfg.max_iv  <= 16'd2000;
            r_cfg.warmup  <= 16'd100;
            r_cfg.decay   <= 10'd100;
            r_cfg.min_n   <= 4'd2;
            r_cfg.alpha   <= 16'd328;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_idx))
                REG_MIN_AMP: r_cfg.min_amp <= i_cfg_data;
                REG_MIN_IV:  r_cfg.min_iv  <= i_cfg_data;
                REG_MAX_IV:  r_cfg.max_iv  <= i_cfg_data;
                REG_WARMUP:  r_cfg.warmup  <= i_cfg_data;
                REG_DECAY:   r_cfg.decay   <= i_cfg_data[9:0];
                REG_MIN_N:   r_cfg.min_n   <= i_cfg_data[3:0];
                REG_ALPHA:   r_cfg.alpha   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The front end only takes an item when the queue has room for its job.
    assign o_full = !front_ready;

    pph_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (i_push),
        .o_ready     (front_ready),
        .i_kind      (i_kind),
        .i_ir_sample (i_ir_sample),
        .i_time_ms   (i_time_ms),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_job     (q_in)
    );

    pph_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    pph_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_q_empty          (q_empty),
        .i_q_job            (q_out),
        .o_q_pop            (q_pop),
        .i_pop              (i_pop),
        .o_empty            (o_empty),
        .o_peak_found       (o_peak_found),
        .o_heart_rate_q8    (o_heart_rate_q8),
        .o_stored_intervals (o_stored_intervals),
        .o_beat_total       (o_beat_total)
    );

endmodule

// ===== hw/rtl/pph_checker.sv =====
// Port-level checker for the PPG heart rate block, bound to the top level.
`include "assert_macros.svh"

module pph_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_pop,
    input logic        o_empty,
    input logic        o_peak_found,
    input logic [15:0] o_heart_rate_q8,
    input logic [3:0]  o_stored_intervals,
    input logic [31:0] o_beat_total
);

    // A confirmed beat always lands in the ring and bumps the total.
    `PPH_ASSERT_IMP(a_peak_counts, i_clk, i_rst_n, !o_empty && o_peak_found, (o_beat_total != 32'd0) && (o_stored_intervals != 4'd0), "peak without stored interval")

    // With fewer than two intervals no rate can be formed.
    `PPH_ASSERT_IMP(a_rate_needs_two, i_clk, i_rst_n, !o_empty && (o_stored_intervals < 4'd2), o_heart_rate_q8 == 16'd0, "rate reported from too few intervals")

    // A waiting item holds until it is popped.
    `PPH_ASSERT_NXT(a_hold, i_clk, i_rst_n, !o_empty && !i_pop, !o_empty && $stable(o_beat_total) && $stable(o_heart_rate_q8), "waiting item changed")

endmodule

bind pulse_peak_heart_rate_top pph_checker u_chk (.*);

// ===== verif/pulse_peak_heart_rate_top_tb.sv =====
// Self-checking testbench for the PPG peak detector and heart rate block.
module pulse_peak_heart_rate_top_tb;
    import pph_pkg::*;

    // Item kinds on i_kind.
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // The watchdog fires once the run of cycles in which nothing moves reaches
    // this limit. The slowest correct gap is a sender gap plus a receiver stall
    // plus one rate job, or the settle time between phases; it is many times that.
    localparam int STALL_LIMIT  = 5000;
    // Cycles allowed after the last result for any work still in flight.
    localparam int SETTLE_CYCLES = 120;
    localparam int RANDOM_ITEMS  = 1200;

    typedef struct {
        logic        kind;
        logic [15:0] ir;
        logic [31:0] t_ms;
    } ppg_item_t;

    typedef struct {
        logic        peak;
        logic [15:0] bpm_q8;
        logic [3:0]  fill;
        logic [31:0] beats;
    } beat_report_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic        i_kind = 1'b0;
    logic [15:0] i_ir_sample = '0;
    logic [31:0] i_time_ms = '0;
    logic        i_pop = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        o_full;
    logic        o_empty;
    logic        o_peak_found;
    logic [15:0] o_heart_rate_q8;
    logic [3:0]  o_stored_intervals;
    logic [31:0] o_beat_total;

    pulse_peak_heart_rate_top DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (i_push),
        .o_full             (o_full),
        .i_kind             (i_kind),
        .i_ir_sample        (i_ir_sample),
        .i_time_ms          (i_time_ms),
        .i_pop              (i_pop),
        .o_empty            (o_empty),
        .o_peak_found       (o_peak_found),
        .o_heart_rate_q8    (o_heart_rate_q8),
        .o_stored_intervals (o_stored_intervals),
        .o_beat_total       (o_beat_total),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Beat predictor: its own copy of the registers and detection state.
    // ------------------------------------------------------------------
    logic [15:0] p_min_amp, p_min_iv, p_max_iv, p_warmup, p_alpha;
    logic [9:0]  p_decay;
    logic [3:0]  p_min_n;

    logic [15:0] st_high, st_low, st_warm, st_last, st_older;
    logic [9:0]  st_since;
    logic        st_armed;
    logic [31:0] st_base, st_last_beat, st_beats;
    logic [15:0] st_ring [SLOTS];
    logic [2:0]  st_ptr;
    logic [3:0]  st_fill;

    function automatic void clear_detector(logic [31:0] now);
        st_high = '0;
        st_low = 16'hFFFF;
        st_since = '0;
        st_armed = 1'b1;
        st_base = '0;
        st_warm = '0;
        st_last_beat = now;
        for (int i = 0; i < SLOTS; i++) st_ring[i] = '0;
        st_ptr = '0;
        st_fill = '0;
        st_beats = '0;
    endfunction

    function automatic void defaults_after_reset();
        p_min_amp = 16'd100;
        p_min_iv = 16'd300;
        p_max_iv = 16'd2000;
        p_warmup = 16'd100;
        p_decay = 10'd100;
        p_min_n = 4'd2;
        p_alpha = 16'd328;
        clear_detector('0);
        st_last = '0;
        st_older = '0;
    endfunction

    function automatic void apply_register(t_reg idx, logic [15:0] d);
        case (idx)
            REG_MIN_AMP: p_min_amp = d;
            REG_MIN_IV:  p_min_iv = d;
            REG_MAX_IV:  p_max_iv = d;
            REG_WARMUP:  p_warmup = d;
            REG_DECAY:   p_decay = d[9:0];
            REG_MIN_N:   p_min_n = d[3:0];
            REG_ALPHA:   p_alpha = d;
            default: ;
        endcase
    endfunction

    function automatic logic [15:0] bpm_from(logic [63:0] n, logic [63:0] s, bit limited);
        logic [63:0] q;
        if (s == 0) return '0;
        if (limited && (60000 * n < 30 * s || 60000 * n > 200 * s)) return '0;
        q = (64'd15360000 * n) / s;
        return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    // Rate from the mean interval with outliers beyond 30% of the mean dropped.
    function automatic logic [15:0] current_bpm();
        logic [63:0] s1, n1, s2, n2, v, a, b, d;
        s1 = 0; n1 = 0; s2 = 0; n2 = 0;
        if (st_fill < p_min_n) return '0;
        for (int i = 0; i < st_fill && i < SLOTS; i++) begin
            v = st_ring[i];
            if (v >= p_min_iv && v <= p_max_iv) begin
                s1 += v;
                n1++;
            end
        end
        if (n1 < 2) return '0;
        for (int i = 0; i < st_fill && i < SLOTS; i++) begin
            v = st_ring[i];
            a = 10 * n1 * v;
            b = 10 * s1;
            d = (a > b) ? a - b : b - a;
            if (d <= 3 * s1) begin
                s2 += v;
                n2++;
            end
        end
        if (n2 < 2) return bpm_from(n1, s1, 1'b0);
        return bpm_from(n2, s2, 1'b1);
    endfunction

    function automatic logic track_sample(logic [15:0] x, logic [31:0] now);
        logic        peak;
        logic [10:0] nxt;
        logic [15:0] dec, thr;
        int          span;
        logic [63:0] target, diff, stepv;
        logic [31:0] iv;
        peak = 1'b0;
        if (x > st_high) st_high = x;
        if (x < st_low) st_low = x;
        nxt = {1'b0, st_since} + 11'd1;
        if (nxt > {1'b0, p_decay}) begin
            dec = (st_high >= st_low) ? (st_high - st_low) >> 5 : '0;
            st_high -= dec;
            st_low += dec;
            st_since = '0;
        end else begin
            st_since = nxt[9:0];
        end
        span = int'({16'd0, st_high}) - int'({16'd0, st_low});

        // Baseline in Q16.16; the downward step rounds toward minus infinity.
        target = {32'd0, x, 16'd0};
        if (st_base == 0) begin
            st_base = target[31:0];
        end else if (target >= st_base) begin
            diff = target - st_base;
            stepv = (diff * p_alpha) >> 16;
            st_base += stepv[31:0];
        end else begin
            diff = st_base - target;
            stepv = (diff * p_alpha + 65535) >> 16;
            st_base -= stepv[31:0];
        end
        thr = st_base[31:16];

        if (st_warm != 16'hFFFF) st_warm++;
        if (st_warm >= p_warmup) begin
            if (st_armed) begin
                if (st_last > st_older && st_last > x && st_last > thr &&
                    span > int'({16'd0, p_min_amp})) begin
                    iv = now - st_last_beat;
                    if (iv >= p_min_iv && iv <= p_max_iv) begin
                        st_ring[st_ptr] = iv[15:0];
                        st_ptr++;
                        if (st_fill < SLOTS) st_fill++;
                        st_beats++;
                        peak = 1'b1;
                        st_since = '0;
                    end
                    st_last_beat = now;
                    st_armed = 1'b0;
                end
            end else if (x < thr) begin
                st_armed = 1'b1;
            end
        end
        st_older = st_last;
        st_last = x;
        return peak;
    endfunction

    function automatic beat_report_t predict_report(ppg_item_t it);
        beat_report_t r;
        r.peak = 1'b0;
        if (it.kind == KIND_RESTART) clear_detector(it.t_ms);
        else r.peak = track_sample(it.ir, it.t_ms);
        r.bpm_q8 = current_bpm();
        r.fill = st_fill;
        r.beats = st_beats;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver, monitor and watchdog.
    // ------------------------------------------------------------------
    ppg_item_t    pending_items[$];
    beat_report_t expected_reports[$];
    int  errors = 0;
    int  items_sent = 0;
    int  reports_seen = 0;
    int  peaks_seen = 0;
    int  send_gap = 0;
    int  pop_stall = 0;
    bit  no_idle = 0;      // when set, both sides run back to back
    int  quiet_cycles = 0;
    logic [31:0] clock_ms = '0;

    // The driver presents the next pending item after a random gap. When the gap
    // drawn is zero, push stays high and the next item follows directly.
    always @(posedge i_clk) begin
        ppg_item_t nxt_item;
        int        g;
        if (!i_rst_n) begin
            i_push <= 1'b0;
            send_gap <= 0;
        end else if (i_push && !o_full) begin
            expected_reports.push_back(predict_report('{i_kind, i_ir_sample, i_time_ms}));
            items_sent++;
            g = no_idle ? 0 : $urandom_range(0, 11);
            if (g == 0 && pending_items.size() > 0) begin
                nxt_item = pending_items.pop_front();
                i_kind <= nxt_item.kind;
                i_ir_sample <= nxt_item.ir;
                i_time_ms <= nxt_item.t_ms;
            end else begin
                i_push <= 1'b0;
                send_gap <= g;
            end
        end else if (!i_push) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_items.size() > 0) begin
                nxt_item = pending_items.pop_front();
                i_kind <= nxt_item.kind;
                i_ir_sample <= nxt_item.ir;
                i_time_ms <= nxt_item.t_ms;
                i_push <= 1'b1;
            end
        end
    end

    // The monitor pops with random stalls and compares every field of each
    // result with the oldest prediction.
    always @(posedge i_clk) begin
        beat_report_t w;
        int           s;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
            pop_stall <= 0;
        end else if (i_pop && !o_empty) begin
            reports_seen++;
            if (o_peak_found) peaks_seen++;
            if (expected_reports.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: peak %0b rate %0d fill %0d beats %0d",
                         $time, o_peak_found, o_heart_rate_q8, o_stored_intervals,
                         o_beat_total);
            end else begin
                w = expected_reports.pop_front();
                if (o_peak_found !== w.peak) begin
                    errors++;
                    $display("%0t: peak_found expected %0b actual %0b",
                             $time, w.peak, o_peak_found);
                end
                if (o_heart_rate_q8 !== w.bpm_q8) begin
                    errors++;
                    $display("%0t: heart_rate_q8 expected %0d actual %0d",
                             $time, w.bpm_q8, o_heart_rate_q8);
                end
                if (o_stored_intervals !== w.fill) begin
                    errors++;
                    $display("%0t: stored_intervals expected %0d actual %0d",
                             $time, w.fill, o_stored_intervals);
                end
                if (o_beat_total !== w.beats) begin
                    errors++;
                    $display("%0t: beat_total expected %0d actual %0d",
                             $time, w.beats, o_beat_total);
                end
            end
            s = no_idle ? 0 : $urandom_range(0, 11);
            if (s != 0) begin
                i_pop <= 1'b0;
                pop_stall <= s;
            end
        end else if (!i_pop) begin
            if (pop_stall > 0) pop_stall <= pop_stall - 1;
            else i_pop <= 1'b1;
        end
    end

    // Any accepted item, result or register write counts as progress.
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty) || i_cfg_we || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d quiet cycles", quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    task automatic write_register(t_reg idx, logic [15:0] d);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        apply_register(idx, d);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until the sender has nothing left and every result has come back,
    // then lets the rate engine settle before the registers change.
    task automatic drain();
        @(posedge i_clk);
        while (pending_items.size() > 0 || i_push || expected_reports.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_item(logic kind, logic [15:0] ir, logic [31:0] t_ms);
        pending_items.push_back('{kind, ir, t_ms});
    endtask

    // A pulse train: a steep rise over a quarter of each beat and a slow fall,
    // riding on a DC level with a little noise. Period jitter makes some
    // intervals outliers or out of window.
    task automatic add_pulse_train(int count, int period, int amp, int dc, int noise,
                                   int step_ms, int jitter);
        int ph, cur_period, v, rise;
        ph = $urandom_range(0, period - 1);
        cur_period = period;
        for (int k = 0; k < count; k++) begin
            rise = (cur_period / 4 > 0) ? cur_period / 4 : 1;
            if (ph < rise) v = dc + amp * ph / rise;
            else v = dc + amp - amp * (ph - rise) / (cur_period - rise + 1);
            v += int'($urandom_range(0, 2 * noise)) - noise;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            clock_ms += step_ms;
            add_item(KIND_SAMPLE, v[15:0], clock_ms);
            ph++;
            if (ph >= cur_period) begin
                ph = 0;
                cur_period = period + int'($urandom_range(0, 2 * jitter)) - jitter;
                if (cur_period < 3) cur_period = 3;
            end
        end
    endtask

    task automatic random_registers();
        write_register(REG_MIN_AMP, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(0, 3000)));
        write_register(REG_MIN_IV, 16'($urandom_range(1, 700)));
        write_register(REG_MAX_IV, ($urandom_range(0, 5) == 0) ? 16'($urandom_range(1, 65535))
                                                            : 16'($urandom_range(900, 3000)));
        write_register(REG_WARMUP, 16'($urandom_range(0, 150)));
        write_register(REG_DECAY, 16'($urandom_range(1, 1023)));
        write_register(REG_MIN_N, 16'($urandom_range(2, 8)));
        write_register(REG_ALPHA, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                           : 16'($urandom_range(50, 4000)));
    endtask

    initial begin
        int seg;
        defaults_after_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under reset defaults: restart, sample extremes, a zero
        // sample that reloads the baseline, all-ones time bits, and a short burst.
        add_item(KIND_RESTART, 16'hFFFF, 32'hFFFF_FFFF);
        add_item(KIND_SAMPLE, 16'h0000, 32'h0000_0000);
        add_item(KIND_SAMPLE, 16'hFFFF, 32'hFFFF_FFFF);
        add_item(KIND_SAMPLE, 16'h0000, 32'h5555_5555);
        add_item(KIND_SAMPLE, 16'hAAAA, 32'hAAAA_AAAA);
        add_item(KIND_RESTART, 16'h0000, 32'h0000_0000);
        drain();

        // Peaks right away: no warmup, decay every second sample, lowest limits, largest alpha.
        write_register(REG_WARMUP, 16'd0);
        write_register(REG_DECAY, 16'd1);
        write_register(REG_MIN_AMP, 16'd0);
        write_register(REG_MIN_IV, 16'd1);
        write_register(REG_MAX_IV, 16'hFFFF);
        write_register(REG_MIN_N, 16'd2);
        write_register(REG_ALPHA, 16'hFFFF);
        clock_ms = 32'hFFFF_FF00;   // the interval arithmetic crosses the time wrap
        add_item(KIND_RESTART, 16'd0, clock_ms);
        add_pulse_train(18, 4, 40000, 1000, 0, 17, 0);
        drain();

        // Extreme registers: peaks need an impossible range, warmup outlasts the train.
        write_register(REG_MIN_AMP, 16'hFFFF);
        write_register(REG_WARMUP, 16'hFFFF);
        write_register(REG_DECAY, 16'd1023);
        write_register(REG_MIN_N, 16'd8);
        write_register(REG_ALPHA, 16'd1);
        no_idle = 1;
        add_pulse_train(60, 20, 30000, 2000, 500, 10, 0);
        drain();
        no_idle = 0;

        // Random part: several register settings, mostly realistic pulse trains
        // with random shape, plus noise, restarts and the occasional time jump.
        // A round adds over 300 items, so stopping short of the target
        // lands the total near it.
        while (items_sent < RANDOM_ITEMS - 150) begin
            random_registers();
            no_idle = ($urandom_range(0, 3) == 0);
            add_item(KIND_RESTART, 16'($urandom), clock_ms);
            for (int k = 0; k < 300; k += seg) begin
                case ($urandom_range(0, 9))
                    0: begin
                        seg = $urandom_range(3, 12);
                        for (int j = 0; j < seg; j++) begin
                            clock_ms += $urandom_range(0, 50);
                            add_item(KIND_SAMPLE, 16'($urandom), clock_ms);
                        end
                    end
                    1: begin
                        seg = 1;
                        if ($urandom_range(0, 1)) clock_ms = $urandom;
                        add_item(KIND_RESTART, 16'($urandom), clock_ms);
                    end
                    default: begin
                        seg = $urandom_range(40, 150);
                        add_pulse_train(seg, $urandom_range(6, 150), $urandom_range(100, 30000),
                                        $urandom_range(0, 30000), $urandom_range(0, 200),
                                        $urandom_range(5, 20), $urandom_range(0, 10));
                    end
                endcase
            end
            drain();
        end

        $display("Covered %0d items and %0d results with %0d detected beats,", items_sent,
                 reports_seen, peaks_seen);
        $display("across register extremes, restarts, time wrap and random handshake gaps.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== pulse_peak_heart_rate_top.f =====
+incdir+hw/rtl
hw/rtl/pph_pkg.sv
hw/rtl/pph_front.sv
hw/rtl/pph_fifo.sv
hw/rtl/pph_back.sv
hw/rtl/pulse_peak_heart_rate_top.sv
hw/rtl/pph_checker.sv
verif/pulse_peak_heart_rate_top_tb.sv
